>>> sv/pits_pkg.sv
// ----------------------------------------------------------------------------
// pits_pkg: shared constants for the poisson inverse transform sampler
// widths of the fixed point datapath, register indexes and count saturation
// ----------------------------------------------------------------------------
package pits_pkg;

	localparam int MAX_COUNT = 255;
	localparam int KW        = $clog2(MAX_COUNT + 1);

	localparam int MEAN_W    = 21;
	localparam int PROB_W    = 32;
	localparam int FRAC_PAD  = 15;
	localparam int VAL_W     = 48;
	localparam int HALF_W    = 24;
	localparam int PROD_W    = HALF_W + MEAN_W;
	localparam int DIG_W     = 8;
	localparam int DIV_W     = 56;
	localparam int DIV_STEPS = DIV_W / DIG_W;
	localparam int DCNT_W    = $clog2(DIV_STEPS);
	localparam int COUNT_W   = 8;
	localparam int IDX_W     = 8;
	localparam int CFG_W     = 32;

	localparam logic [MEAN_W-1:0] MEAN_LIMIT = MEAN_W'(1048576);
	localparam logic [MEAN_W-1:0] MEAN_RESET = MEAN_W'(65536);
	localparam logic [PROB_W-1:0] START_RESET = PROB_W'(32'd1580030169);
	localparam logic [VAL_W-1:0]  SAT_VAL = {VAL_W{1'b1}};

	localparam logic [IDX_W-1:0] REG_MEAN  = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_START = IDX_W'(1);

	typedef logic [KW-1:0] count_t;

	function automatic logic [COUNT_W-1:0] sat_count(input count_t k);
		logic [31:0] kx;
		kx = 32'(k);
		return (kx > 32'd255) ? {COUNT_W{1'b1}} : kx[COUNT_W-1:0];
	endfunction

endpackage

>>> sv/poisson_inverse_transform_sampler_top.sv
// each step of k takes one check, two passes of the shared 24x21 multiplier,
// the 8 bit per cycle divider by k+1 and one accumulate
// requests: one in flight, the next taken once the sequencer is back in idle,
// which needs the output free; a waiting result holds the sequencer in its final check
// reset: asynchronous, clears the sequencer and the output valid, loads the register defaults
// ----------------------------------------------------------------------------
// poisson_inverse_transform_sampler_top
// smallest k whose poisson cumulative probability reaches a uniform request
// ----------------------------------------------------------------------------
module poisson_inverse_transform_sampler_top
	import pits_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [PROB_W-1:0]   s_axis_tdata,   // uniform_p [31:0]
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [COUNT_W-1:0]  m_axis_tdata,   // count [7:0]
	output logic                m_axis_tuser    // capped [0]
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CHECK  = 3'd1;
	localparam logic [2:0] ST_MUL_HI = 3'd2;
	localparam logic [2:0] ST_MUL_LO = 3'd3;
	localparam logic [2:0] ST_DIV    = 3'd4;
	localparam logic [2:0] ST_ACC    = 3'd5;

	logic [2:0]          state_q;
	logic [MEAN_W-1:0]   mean_q;
	logic [PROB_W-1:0]   start_q;
	logic [MEAN_W-1:0]   mean_use_q;
	logic [VAL_W-1:0]    target_q;
	logic [VAL_W-1:0]    term_q;
	logic [VAL_W-1:0]    sum_q;
	logic [DIV_W-1:0]    acc_q;
	logic [KW-1:0]       rem_q;
	logic [DCNT_W-1:0]   dcnt_q;
	count_t              k_q;
	logic                m_valid_q;
	logic [COUNT_W-1:0]  count_q;
	logic                capped_q;

	logic [HALF_W-1:0]   mul_a;
	logic [PROD_W-1:0]   prod;
	logic [KW-1:0]       rem_nxt;
	logic [DIG_W-1:0]    qdig;
	logic [VAL_W-1:0]    term_new;
	logic [VAL_W:0]      sum_ext;
	logic                out_free;
	logic                hit;
	logic                at_max;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = count_q;
	assign m_axis_tuser  = capped_q;

	// shared multiplier, upper or lower half of the term
	assign mul_a = (state_q == ST_MUL_HI) ? term_q[VAL_W-1:HALF_W] : term_q[HALF_W-1:0];
	assign prod  = PROD_W'(mul_a) * PROD_W'(mean_use_q);

	// one quotient byte per cycle, restoring steps
	always_comb begin
		logic [KW:0] t;
		logic [KW-1:0] r;
		r = rem_q;
		qdig = '0;
		for (int i = 0; i < DIG_W; i++) begin
			t = {r, acc_q[DIV_W-1-i]};
			if (t >= {1'b0, k_q}) begin
				t = t - {1'b0, k_q};
				qdig[DIG_W-1-i] = 1'b1;
			end
			r = t[KW-1:0];
		end
		rem_nxt = r;
	end

	assign term_new = (acc_q[DIV_W-1:VAL_W] != '0) ? SAT_VAL : acc_q[VAL_W-1:0];
	assign sum_ext  = {1'b0, sum_q} + {1'b0, term_new};

	assign out_free = !m_valid_q || m_axis_tready;
	assign hit      = (sum_q >= target_q);
	assign at_max   = (k_q >= KW'(MAX_COUNT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_q  <= MEAN_RESET;
			start_q <= START_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_MEAN) begin
				mean_q <= cfg_data[MEAN_W-1:0];
			end else if (cfg_index == REG_START) begin
				start_q <= cfg_data[PROB_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
			k_q       <= '0;
			dcnt_q    <= '0;
		end else begin
			if ((state_q == ST_CHECK) && (hit || at_max) && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						k_q     <= '0;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (hit || at_max) begin
						if (out_free) begin
							state_q <= ST_IDLE;
						end
					end else begin
						k_q     <= k_q + KW'(1);
						state_q <= ST_MUL_HI;
					end
				end
				ST_MUL_HI: state_q <= ST_MUL_LO;
				ST_MUL_LO: begin
					dcnt_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					dcnt_q <= dcnt_q + DCNT_W'(1);
					if (dcnt_q == DCNT_W'(DIV_STEPS - 1)) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: state_q <= ST_CHECK;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				target_q   <= {1'b0, s_axis_tdata, FRAC_PAD'(0)};
				mean_use_q <= (mean_q > MEAN_LIMIT) ? MEAN_LIMIT : mean_q;
				term_q     <= {1'b0, start_q, FRAC_PAD'(0)};
				sum_q      <= {1'b0, start_q, FRAC_PAD'(0)};
			end
			ST_CHECK: begin
				if ((hit || at_max) && out_free) begin
					count_q  <= sat_count(k_q);
					capped_q <= !hit;
				end
			end
			ST_MUL_HI: acc_q <= DIV_W'(prod) << DIG_W;
			ST_MUL_LO: begin
				acc_q <= acc_q + DIV_W'(prod >> 16);
				rem_q <= '0;
			end
			ST_DIV: begin
				acc_q <= {acc_q[DIV_W-DIG_W-1:0], qdig};
				rem_q <= rem_nxt;
			end
			ST_ACC: begin
				term_q <= term_new;
				sum_q  <= sum_ext[VAL_W] ? SAT_VAL : sum_ext[VAL_W-1:0];
			end
			default: ;
		endcase
	end

`ifndef SYNTH
	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= KW'(MAX_COUNT))
		else $error("count beyond search limit");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < k_q))
		else $error("divider remainder not below divisor");

	a_capped_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == sat_count(KW'(MAX_COUNT))))
		else $error("capped result without maximum count");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> (state_q == ST_CHECK && k_q == '0))
		else $error("request did not start a search at zero");
`endif

endmodule
